>>> rtl/ppm_frame_generator_macros.svh
// ----------------------------------------------------------------------------
// ppm_frame_generator_macros.svh
// Assertion macros shared by the PPM frame generator modules.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_GENERATOR_MACROS_SVH
`define PPM_FRAME_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PPMFG_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ppm frame generator: check failed");
`define PPMFG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppm frame generator: check failed");
`else
`define PPMFG_ASSERT(label, prop)
`define PPMFG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> rtl/ppmfg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator package
// Widths, codes, reset values and shared structs of the frame generator.
// ----------------------------------------------------------------------------
package ppmfg_pkg;

	localparam int MAX_CHANNELS = 16;
	localparam int START_DELAY  = 100;

	localparam int CHAN_W    = $clog2(MAX_CHANNELS);
	localparam int PTR_W     = $clog2(MAX_CHANNELS + 1);
	localparam int COUNT_W   = 5;
	localparam int WIDTH_W   = 12;
	localparam int FRAME_W   = 16;
	localparam int ELAPSED_W = 17;
	localparam int VALUE_W   = 16;
	localparam int MODE_W    = 2;
	localparam int INDEX_W   = 4;
	localparam int PCT_W     = 7;
	localparam int PROD_W    = WIDTH_W + PCT_W;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for every x below 2**PROD_W
	localparam int RECIP_SHIFT = 26;
	localparam int RECIP_W     = 20;
	localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'((1 << RECIP_SHIFT) / 100 + 1);

	localparam logic [PCT_W-1:0]     PCT_FULL    = PCT_W'(100);
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic [COUNT_W-1:0] RST_COUNT = COUNT_W'(8);
	localparam logic [WIDTH_W-1:0] RST_MIN   = WIDTH_W'(1000);
	localparam logic [WIDTH_W-1:0] RST_MAX   = WIDTH_W'(2000);
	localparam logic [WIDTH_W-1:0] RST_PULSE = WIDTH_W'(500);
	localparam logic [FRAME_W-1:0] RST_FRAME = FRAME_W'(22500);

	localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WIDTH   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PERCENT = 2'd2;

	localparam int REG_W   = 3;
	localparam int PADDR_W = REG_W + 2;
	localparam logic [REG_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [REG_W-1:0] REG_INVERTED      = 3'd1;
	localparam logic [REG_W-1:0] REG_ENABLED       = 3'd2;
	localparam logic [REG_W-1:0] REG_MIN_WIDTH     = 3'd3;
	localparam logic [REG_W-1:0] REG_MAX_WIDTH     = 3'd4;
	localparam logic [REG_W-1:0] REG_PULSE_LEN     = 3'd5;
	localparam logic [REG_W-1:0] REG_FRAME_LEN     = 3'd6;

	typedef struct packed {
		logic [COUNT_W-1:0] channel_count;
		logic               inverted;
		logic               enabled;
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] max_width;
		logic [WIDTH_W-1:0] pulse_len;
		logic [FRAME_W-1:0] frame_len;
	} cfg_t;

	typedef struct packed {
		logic en_wr;
		logic inv_wr;
		logic wbit;
	} cfg_evt_t;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [INDEX_W-1:0] chan_index;
		logic [VALUE_W-1:0] width_value;
	} item_t;

	typedef struct packed {
		logic pin_level;
		logic edge_res;
		logic sync_gap;
	} res_t;

	typedef struct packed {
		logic               we;
		logic [CHAN_W-1:0]  addr;
		logic [WIDTH_W-1:0] data;
	} tbl_wr_t;

endpackage

>>> rtl/ppmfg_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator input channel
// Valid/ready channel carrying one tick or channel width write per word.
// ----------------------------------------------------------------------------
interface ppmfg_in_if;
	logic                            valid;
	logic                            ready;
	logic [ppmfg_pkg::MODE_W-1:0]    mode;
	logic [ppmfg_pkg::INDEX_W-1:0]   chan_index;
	logic [ppmfg_pkg::VALUE_W-1:0]   width_value;

	modport source (output valid, mode, chan_index, width_value, input ready);
	modport sink (input valid, mode, chan_index, width_value, output ready);
endinterface

>>> rtl/ppmfg_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator result channel
// Valid/ready channel carrying the pin state after each input word.
// ----------------------------------------------------------------------------
interface ppmfg_out_if;
	logic valid;
	logic ready;
	logic pin_level;
	logic edge_res;
	logic sync_gap;

	modport source (output valid, pin_level, edge_res, sync_gap, input ready);
	modport sink (input valid, pin_level, edge_res, sync_gap, output ready);
endinterface

>>> rtl/ppm_frame_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator
// Drives an RC pulse-position frame from tick and channel width words.
// ----------------------------------------------------------------------------
// A word accepted into s1 moves through the s2 and result registers in order.
// Throughput: one word per cycle while results are taken; one table read and
// one write a cycle. Stages s1 and s2 take new words while a result waits.
// Reset: asynchronous, active low; registers to defaults, pin at idle high,
// width table reads as the reset minimum width until each entry is written.
// ----------------------------------------------------------------------------
module ppm_frame_generator (
	input  logic                             clk,
	input  logic                             arst_n,
	ppmfg_in_if.sink                         item,
	ppmfg_out_if.source                      res,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ppmfg_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	ppmfg_pkg::cfg_t                    cfg;
	ppmfg_pkg::cfg_evt_t                evt;
	ppmfg_pkg::item_t                   item_in;
	ppmfg_pkg::item_t                   item_s2;
	ppmfg_pkg::tbl_wr_t                 tbl_wr;
	ppmfg_pkg::res_t                    step_res;
	ppmfg_pkg::res_t                    res_s3;
	logic [ppmfg_pkg::CHAN_W-1:0]       rd_addr;
	logic [ppmfg_pkg::WIDTH_W-1:0]      rd_width;
	logic                               valid_s1, valid_s2, valid_s3;
	logic                               ready_s1, ready_s2, ready_s3;
	logic                               ld_s1, ld_s2, step;

	assign item_in.mode        = item.mode;
	assign item_in.chan_index  = item.chan_index;
	assign item_in.width_value = item.width_value;

	// each stage moves when the one after it has room
	assign ready_s3   = !valid_s3 || res.ready;
	assign step       = valid_s2 && ready_s3;
	assign ready_s2   = !valid_s2 || ready_s3;
	assign ld_s2      = valid_s1 && ready_s2;
	assign ready_s1   = !valid_s1 || ready_s2;
	assign ld_s1      = item.valid && ready_s1;
	assign item.ready = ready_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= ld_s1 || (valid_s1 && !ld_s2);
			valid_s2 <= ld_s2 || (valid_s2 && !step);
			valid_s3 <= step || (valid_s3 && !res.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_s3 <= step_res;
		end
	end

	assign res.valid     = valid_s3;
	assign res.pin_level = res_s3.pin_level;
	assign res.edge_res  = res_s3.edge_res;
	assign res.sync_gap  = res_s3.sync_gap;

	ppmfg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg),
		.evt     (evt)
	);

	ppmfg_width_calc u_width_calc (
		.clk     (clk),
		.ld_s1   (ld_s1),
		.ld_s2   (ld_s2),
		.item_in (item_in),
		.cfg     (cfg),
		.item_s2 (item_s2)
	);

	ppmfg_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd_addr (rd_addr),
		.rd_data (rd_width)
	);

	ppmfg_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.evt      (evt),
		.step     (step),
		.item     (item_s2),
		.rd_width (rd_width),
		.wr       (tbl_wr),
		.rd_addr  (rd_addr),
		.step_res (step_res)
	);

endmodule

>>> rtl/ppmfg_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator register file
// APB register bank; flags enable and polarity writes for the sequencer.
// ----------------------------------------------------------------------------
module ppmfg_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ppmfg_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready,
	output ppmfg_pkg::cfg_t                  cfg,
	output ppmfg_pkg::cfg_evt_t              evt
);

	logic                               wr_en;
	logic [ppmfg_pkg::REG_W-1:0]        reg_idx;
	logic [ppmfg_pkg::COUNT_W-1:0]      count_new;
	ppmfg_pkg::cfg_t                    cfg_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ppmfg_pkg::PADDR_W-1:2];
	assign cfg     = cfg_q;

	assign evt.en_wr  = wr_en && (reg_idx == ppmfg_pkg::REG_ENABLED);
	assign evt.inv_wr = wr_en && (reg_idx == ppmfg_pkg::REG_INVERTED);
	assign evt.wbit   = pwdata[0];

	// zero selects the default count, oversize saturates
	always_comb begin
		count_new = pwdata[ppmfg_pkg::COUNT_W-1:0];
		if (count_new == '0) begin
			count_new = ppmfg_pkg::RST_COUNT;
		end else if (32'(count_new) > ppmfg_pkg::MAX_CHANNELS) begin
			count_new = ppmfg_pkg::COUNT_W'(ppmfg_pkg::MAX_CHANNELS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_count <= ppmfg_pkg::RST_COUNT;
			cfg_q.inverted      <= 1'b0;
			cfg_q.enabled       <= 1'b0;
			cfg_q.min_width     <= ppmfg_pkg::RST_MIN;
			cfg_q.max_width     <= ppmfg_pkg::RST_MAX;
			cfg_q.pulse_len     <= ppmfg_pkg::RST_PULSE;
			cfg_q.frame_len     <= ppmfg_pkg::RST_FRAME;
		end else if (wr_en) begin
			unique case (reg_idx)
				ppmfg_pkg::REG_CHANNEL_COUNT: cfg_q.channel_count <= count_new;
				ppmfg_pkg::REG_INVERTED:      cfg_q.inverted <= pwdata[0];
				ppmfg_pkg::REG_ENABLED:       cfg_q.enabled <= pwdata[0];
				ppmfg_pkg::REG_MIN_WIDTH:
					cfg_q.min_width <= pwdata[ppmfg_pkg::WIDTH_W-1:0];
				ppmfg_pkg::REG_MAX_WIDTH:
					cfg_q.max_width <= pwdata[ppmfg_pkg::WIDTH_W-1:0];
				ppmfg_pkg::REG_PULSE_LEN:
					cfg_q.pulse_len <= pwdata[ppmfg_pkg::WIDTH_W-1:0];
				ppmfg_pkg::REG_FRAME_LEN:
					cfg_q.frame_len <= pwdata[ppmfg_pkg::FRAME_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			ppmfg_pkg::REG_CHANNEL_COUNT: prdata = 32'(cfg_q.channel_count);
			ppmfg_pkg::REG_INVERTED:      prdata = 32'(cfg_q.inverted);
			ppmfg_pkg::REG_ENABLED:       prdata = 32'(cfg_q.enabled);
			ppmfg_pkg::REG_MIN_WIDTH:     prdata = 32'(cfg_q.min_width);
			ppmfg_pkg::REG_MAX_WIDTH:     prdata = 32'(cfg_q.max_width);
			ppmfg_pkg::REG_PULSE_LEN:     prdata = 32'(cfg_q.pulse_len);
			ppmfg_pkg::REG_FRAME_LEN:     prdata = 32'(cfg_q.frame_len);
			default:                      prdata = '0;
		endcase
	end

endmodule

>>> rtl/ppmfg_width_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator width calculator
// Two-stage pipeline turning a percent write into a width in microseconds.
// ----------------------------------------------------------------------------
module ppmfg_width_calc (
	input  logic                 clk,
	input  logic                 ld_s1,
	input  logic                 ld_s2,
	input  ppmfg_pkg::item_t     item_in,
	input  ppmfg_pkg::cfg_t      cfg,
	output ppmfg_pkg::item_t     item_s2
);

	localparam int SCALED_W = ppmfg_pkg::PROD_W + ppmfg_pkg::RECIP_W;

	logic [ppmfg_pkg::PCT_W-1:0]     pct;
	logic [ppmfg_pkg::WIDTH_W-1:0]   span;
	logic [ppmfg_pkg::PROD_W-1:0]    prod;
	logic [ppmfg_pkg::PROD_W-1:0]    prod_s1;
	ppmfg_pkg::item_t                item_s1;
	logic [SCALED_W-1:0]             scaled;
	logic [ppmfg_pkg::WIDTH_W-1:0]   quo;
	logic [ppmfg_pkg::VALUE_W-1:0]   cand;

	always_comb begin
		if (item_in.width_value > ppmfg_pkg::VALUE_W'(ppmfg_pkg::PCT_FULL)) begin
			pct = ppmfg_pkg::PCT_FULL;
		end else begin
			pct = item_in.width_value[ppmfg_pkg::PCT_W-1:0];
		end
		if (cfg.max_width > cfg.min_width) begin
			span = cfg.max_width - cfg.min_width;
		end else begin
			span = '0;
		end
		prod = ppmfg_pkg::PROD_W'(span) * ppmfg_pkg::PROD_W'(pct);
	end

	// divide by 100 through the reciprocal
	assign scaled = SCALED_W'(prod_s1) * SCALED_W'(ppmfg_pkg::RECIP_100);
	assign quo    = scaled[ppmfg_pkg::RECIP_SHIFT +: ppmfg_pkg::WIDTH_W];

	always_comb begin
		if (item_s1.mode == ppmfg_pkg::MODE_PERCENT) begin
			cand = ppmfg_pkg::VALUE_W'({1'b0, cfg.min_width} + {1'b0, quo});
		end else begin
			cand = item_s1.width_value;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			item_s1 <= item_in;
			prod_s1 <= prod;
		end
		if (ld_s2) begin
			item_s2.mode        <= item_s1.mode;
			item_s2.chan_index  <= item_s1.chan_index;
			item_s2.width_value <= cand;
		end
	end

endmodule

>>> rtl/ppmfg_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator width table
// Channel width memory, one write and one registered read per cycle, with write
// forwarding; per-entry valid bits make unwritten entries read as RST_MIN.
// ----------------------------------------------------------------------------
`include "ppm_frame_generator_macros.svh"

module ppmfg_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppmfg_pkg::tbl_wr_t                 wr,
	input  logic [ppmfg_pkg::CHAN_W-1:0]       rd_addr,
	output logic [ppmfg_pkg::WIDTH_W-1:0]      rd_data
);

	logic [ppmfg_pkg::WIDTH_W-1:0]      mem [ppmfg_pkg::MAX_CHANNELS];
	logic [ppmfg_pkg::MAX_CHANNELS-1:0] valid_q;
	logic [ppmfg_pkg::WIDTH_W-1:0]      rd_q;

	assign rd_data = rd_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		// forward a write to the entry being read
		if (wr.we && (wr.addr == rd_addr)) begin
			rd_q <= wr.data;
		end else if (valid_q[rd_addr]) begin
			rd_q <= mem[rd_addr];
		end else begin
			rd_q <= ppmfg_pkg::RST_MIN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.we) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	`PPMFG_ASSERT_NEXT(a_fwd_write, wr.we && (wr.addr == rd_addr), rd_q == $past(wr.data))
	`PPMFG_ASSERT_NEXT(a_unwritten_min, !wr.we && !valid_q[rd_addr], rd_q == ppmfg_pkg::RST_MIN)

endmodule

>>> rtl/ppmfg_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PPM frame generator sequencer
// Countdown, channel pointer and pin state; reads the width of the current
// channel from the table and writes clamped widths back into it.
// ----------------------------------------------------------------------------
`include "ppm_frame_generator_macros.svh"

module ppmfg_seq (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ppmfg_pkg::cfg_t                    cfg,
	input  ppmfg_pkg::cfg_evt_t                evt,
	input  logic                               step,
	input  ppmfg_pkg::item_t                   item,
	input  logic [ppmfg_pkg::WIDTH_W-1:0]      rd_width,
	output ppmfg_pkg::tbl_wr_t                 wr,
	output logic [ppmfg_pkg::CHAN_W-1:0]       rd_addr,
	output ppmfg_pkg::res_t                    step_res
);

	localparam int SUM_W = ppmfg_pkg::ELAPSED_W + 1;

	logic [ppmfg_pkg::PTR_W-1:0]       ptr_q, ptr_d;
	logic [ppmfg_pkg::FRAME_W-1:0]     cnt_q, cnt_d;
	logic [ppmfg_pkg::ELAPSED_W-1:0]   elapsed_q, elapsed_d;
	logic                              pnext_q, pnext_d;
	logic                              pin_q, pin_d;
	logic                              sync_d;
	logic                              tick;
	logic                              expire;
	logic                              chan_end;
	logic                              is_write;
	logic [SUM_W-1:0]                  e_sync;
	logic [SUM_W-1:0]                  e_chan;

	assign tick     = step && (item.mode == ppmfg_pkg::MODE_TICK) && cfg.enabled;
	assign expire   = tick && (cnt_q <= ppmfg_pkg::FRAME_W'(1));
	assign chan_end = (32'(ptr_q) >= 32'(cfg.channel_count))
		|| (32'(ptr_q) >= ppmfg_pkg::MAX_CHANNELS);
	assign e_sync   = SUM_W'(elapsed_q) + SUM_W'(cfg.pulse_len);
	assign e_chan   = SUM_W'(elapsed_q) + SUM_W'(rd_width);

	always_comb begin
		ptr_d     = ptr_q;
		cnt_d     = cnt_q;
		elapsed_d = elapsed_q;
		pnext_d   = pnext_q;
		pin_d     = pin_q;
		sync_d    = 1'b0;
		if (evt.en_wr) begin
			ptr_d     = '0;
			elapsed_d = '0;
			pnext_d   = evt.wbit;
			if (evt.wbit) begin
				cnt_d = ppmfg_pkg::FRAME_W'(ppmfg_pkg::START_DELAY);
			end else begin
				cnt_d = '0;
				pin_d = ~cfg.inverted;
			end
		end else if (evt.inv_wr) begin
			if (!cfg.enabled) begin
				pin_d = ~evt.wbit;
			end
		end else if (tick) begin
			if (!expire) begin
				cnt_d = cnt_q - ppmfg_pkg::FRAME_W'(1);
			end else begin
				pnext_d = ~pnext_q;
				if (pnext_q) begin
					pin_d = cfg.inverted;
					cnt_d = ppmfg_pkg::FRAME_W'(cfg.pulse_len);
				end else begin
					pin_d = ~cfg.inverted;
					if (chan_end) begin
						// sync gap: fill the frame, or one pulse on overrun
						ptr_d     = '0;
						elapsed_d = '0;
						sync_d    = 1'b1;
						if (e_sync < SUM_W'(cfg.frame_len)) begin
							cnt_d = cfg.frame_len - e_sync[ppmfg_pkg::FRAME_W-1:0];
						end else begin
							cnt_d = ppmfg_pkg::FRAME_W'(cfg.pulse_len);
						end
					end else begin
						if (rd_width > cfg.pulse_len) begin
							cnt_d = ppmfg_pkg::FRAME_W'(rd_width - cfg.pulse_len);
						end else begin
							cnt_d = ppmfg_pkg::FRAME_W'(1);
						end
						if (e_chan > SUM_W'(ppmfg_pkg::ELAPSED_MAX)) begin
							elapsed_d = ppmfg_pkg::ELAPSED_MAX;
						end else begin
							elapsed_d = e_chan[ppmfg_pkg::ELAPSED_W-1:0];
						end
						ptr_d = ptr_q + ppmfg_pkg::PTR_W'(1);
					end
				end
			end
		end
	end

	// prefetch the width of the channel that is next in line
	assign rd_addr = ptr_d[ppmfg_pkg::CHAN_W-1:0];

	assign is_write = (item.mode == ppmfg_pkg::MODE_WIDTH)
		|| (item.mode == ppmfg_pkg::MODE_PERCENT);

	always_comb begin
		wr.we = step && is_write
			&& (32'(item.chan_index) < 32'(cfg.channel_count))
			&& (32'(item.chan_index) < ppmfg_pkg::MAX_CHANNELS);
		wr.addr = ppmfg_pkg::CHAN_W'(item.chan_index);
		if (item.width_value < ppmfg_pkg::VALUE_W'(cfg.min_width)) begin
			wr.data = cfg.min_width;
		end else if (item.width_value > ppmfg_pkg::VALUE_W'(cfg.max_width)) begin
			wr.data = cfg.max_width;
		end else begin
			wr.data = item.width_value[ppmfg_pkg::WIDTH_W-1:0];
		end
	end

	assign step_res.pin_level = pin_d;
	assign step_res.edge_res  = expire && (pin_d != pin_q);
	assign step_res.sync_gap  = sync_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q     <= '0;
			cnt_q     <= '0;
			elapsed_q <= '0;
			pnext_q   <= 1'b0;
			pin_q     <= 1'b1;
		end else begin
			ptr_q     <= ptr_d;
			cnt_q     <= cnt_d;
			elapsed_q <= elapsed_d;
			pnext_q   <= pnext_d;
			pin_q     <= pin_d;
		end
	end

	`PPMFG_ASSERT(a_ptr_bound, 32'(ptr_q) <= ppmfg_pkg::MAX_CHANNELS)
	`PPMFG_ASSERT(a_idle_pin, !cfg.enabled |-> (pin_q == !cfg.inverted))
	`PPMFG_ASSERT_NEXT(a_sync_restart, step && sync_d, (ptr_q == '0) && (elapsed_q == '0))

endmodule
